>>> rtl/core/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared constants for the port checker and the bench of the extended gcd unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // cycles from an accepted request beat to the earliest possible result beat
  localparam int unsigned SetupCycles = 2;

endpackage

>>> rtl/core/egcd_in_if.sv
// ----------------------------------------------------------------------------
// egcd_in_if
// Request channel of the extended gcd unit: two signed operands.
// ----------------------------------------------------------------------------
interface egcd_in_if #(
  parameter int DATA_WIDTH = 32
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] first_value;
  logic signed [DATA_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink (input valid, input first_value, input second_value, output ready);

endinterface

>>> rtl/core/egcd_out_if.sv
// ----------------------------------------------------------------------------
// egcd_out_if
// Result channel of the extended gcd unit: gcd and both Bezout coefficients.
// ----------------------------------------------------------------------------
interface egcd_out_if #(
  parameter int DATA_WIDTH = 32
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] gcd_value;
  logic signed [DATA_WIDTH-1:0] coeff_first;
  logic signed [DATA_WIDTH-1:0] coeff_second;

  modport source (output valid, output gcd_value, output coeff_first, output coeff_second,
                  input ready);
  modport sink (input valid, input gcd_value, input coeff_first, input coeff_second,
                output ready);

endinterface

>>> rtl/core/extended_gcd_bezout_unit.sv
// ----------------------------------------------------------------------------
// extended_gcd_bezout_unit
// Extended Euclid on two signed words: gcd plus Bezout coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   req carries first_value and second_value; rsp returns gcd_value,
//   coeff_first and coeff_second with
//   first_value*coeff_first + second_value*coeff_second == gcd_value
//   modulo 2^DATA_WIDTH. Division truncates toward zero, so the gcd keeps
//   the sign the remainders leave it.
//   One item is in flight at a time: req.ready is high only while idle.
//   Every Euclid step runs a restoring divider, one quotient bit per cycle,
//   which also accumulates quotient*coefficient products bit-serially.
//   A step runs through START (setup), DIVIDE (the bit-serial divide) and
//   UPDATE; the result follows a final START once the remainder is zero.
//   n, the number of Euclid steps, is 0 when second_value is zero and
//   at most about 1.44*DATA_WIDTH + 2.
//   The result sits in registers with rsp.valid high until rsp.ready; while
//   the receiver stalls no new request is taken.
//   rst (synchronous) returns the sequencer to idle and drops any item.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_unit #(
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  egcd_in_if.sink     req,
  egcd_out_if.source  rsp
);

  localparam int CntW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    IDLE,
    START,
    DIVIDE,
    UPDATE,
    DONE
  } state_t;

  state_t state;

  logic [DATA_WIDTH-1:0] old_r, cur_r;
  logic [DATA_WIDTH-1:0] old_s, cur_s;
  logic [DATA_WIDTH-1:0] old_t, cur_t;
  logic [DATA_WIDTH-1:0] rem, quo, dvs;
  logic [DATA_WIDTH-1:0] ps, pt;
  logic [CntW-1:0]       cnt;

  logic [DATA_WIDTH:0]   trial;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_next, ps_next, pt_next;
  logic [DATA_WIDTH-1:0] s_new, t_new, r_new;
  logic [DATA_WIDTH-1:0] mag_old, mag_cur;
  logic                  quo_neg;

  // restoring divide step on magnitudes
  assign trial    = {rem, quo[DATA_WIDTH-1]} - {1'b0, dvs};
  assign qbit     = ~trial[DATA_WIDTH];
  assign rem_next = qbit ? trial[DATA_WIDTH-1:0] : {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};

  // quotient magnitude times coefficient, msb first, wraps
  assign ps_next = {ps[DATA_WIDTH-2:0], 1'b0} + (qbit ? cur_s : '0);
  assign pt_next = {pt[DATA_WIDTH-2:0], 1'b0} + (qbit ? cur_t : '0);

  assign quo_neg = old_r[DATA_WIDTH-1] ^ cur_r[DATA_WIDTH-1];
  assign s_new   = quo_neg ? (old_s + ps) : (old_s - ps);
  assign t_new   = quo_neg ? (old_t + pt) : (old_t - pt);
  // remainder takes the sign of the dividend
  assign r_new   = old_r[DATA_WIDTH-1] ? (-rem) : rem;

  // most negative value maps to 2^(W-1) as unsigned
  assign mag_old = old_r[DATA_WIDTH-1] ? (-old_r) : old_r;
  assign mag_cur = cur_r[DATA_WIDTH-1] ? (-cur_r) : cur_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            old_r <= req.first_value;
            cur_r <= req.second_value;
            old_s <= DATA_WIDTH'(1);
            cur_s <= '0;
            old_t <= '0;
            cur_t <= DATA_WIDTH'(1);
            state <= START;
          end
        end
        START: begin
          if (cur_r == '0) begin
            state <= DONE;
          end else begin
            rem   <= '0;
            quo   <= mag_old;
            dvs   <= mag_cur;
            ps    <= '0;
            pt    <= '0;
            cnt   <= CntW'(DATA_WIDTH - 1);
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          rem <= rem_next;
          quo <= {quo[DATA_WIDTH-2:0], qbit};
          ps  <= ps_next;
          pt  <= pt_next;
          if (cnt == '0) begin
            state <= UPDATE;
          end else begin
            cnt <= cnt - CntW'(1);
          end
        end
        UPDATE: begin
          old_r <= cur_r;
          cur_r <= r_new;
          old_s <= cur_s;
          cur_s <= s_new;
          old_t <= cur_t;
          cur_t <= t_new;
          state <= START;
        end
        DONE: begin
          if (rsp.ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == IDLE);
  assign rsp.valid        = (state == DONE);
  assign rsp.gcd_value    = old_r;
  assign rsp.coeff_first  = old_s;
  assign rsp.coeff_second = old_t;

endmodule

>>> rtl/core/egcd_checker.sv
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level assertions for the extended gcd unit, bound into every extended_gcd_bezout_unit.
// ----------------------------------------------------------------------------
module egcd_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  egcd_in_if.sink     req,
  egcd_out_if.source  rsp
);

  logic req_beat;

  assign req_beat = req.valid && req.ready;

  // a waiting result holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.gcd_value)
      && $stable(rsp.coeff_first) && $stable(rsp.coeff_second))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> !req.ready)
    else $error("request taken while busy");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("ready while result pending");

  // zero second operand gives (first, 1, 0) right after setup
  a_zero_second: assert property (@(posedge clk) disable iff (rst)
    req_beat && (req.second_value == '0) |-> ##(egcd_pkg::SetupCycles) (rsp.valid
      && (rsp.gcd_value == $past(req.first_value, egcd_pkg::SetupCycles))
      && (rsp.coeff_first == DATA_WIDTH'(1)) && (rsp.coeff_second == '0)))
    else $error("wrong result for zero second operand");

  // a real division step cannot finish that early
  a_nonzero_second: assert property (@(posedge clk) disable iff (rst)
    req_beat && (req.second_value != '0) |-> ##(egcd_pkg::SetupCycles) !rsp.valid)
    else $error("result too early");

endmodule

bind extended_gcd_bezout_unit egcd_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_egcd_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for extended_gcd_bezout_unit: drives operand pairs over
// the request channel and compares each result beat with the gcd and Bezout
// coefficients that a local truncating-division Euclid predicts.
// ----------------------------------------------------------------------------
module tb;

  localparam int W = 32;
  localparam int RANDOM_ITEMS = 930;
  localparam int LONG_HOLD = 400;
  // worst case is about 1.44*W + 2 Euclid steps; the tail allows for 3*W/2 + 2
  localparam int TAIL_CYCLES = egcd_pkg::SetupCycles + (3 * W / 2 + 2) * (W + 2);
  localparam int STALL_LIMIT = 4 * (TAIL_CYCLES + LONG_HOLD);

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    bit [W-1:0] gcd_value;
    bit [W-1:0] coeff_first;
    bit [W-1:0] coeff_second;
  } bezout_t;

  class bezout_ledger;
    bezout_t     bezout_due[$];
    int unsigned pairs_noted;
    int unsigned results_seen;
    int unsigned fails;

    // euclid with truncating division, coefficients wrap modulo 2^W
    function bezout_t solve_bezout(bit [W-1:0] a, bit [W-1:0] b);
      bit [W-1:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur;
      bit [W-1:0] mag_n, mag_d, quo, rem, nxt;
      bezout_t    res;
      r_prev = a;
      r_cur  = b;
      s_prev = 1;
      s_cur  = 0;
      t_prev = 0;
      t_cur  = 1;
      while (r_cur != 0) begin
        mag_n = r_prev[W-1] ? -r_prev : r_prev;
        mag_d = r_cur[W-1] ? -r_cur : r_cur;
        quo = mag_n / mag_d;
        rem = mag_n % mag_d;
        if (r_prev[W-1] != r_cur[W-1]) quo = -quo;
        if (r_prev[W-1]) rem = -rem;
        r_prev = r_cur;
        r_cur  = rem;
        nxt    = s_prev - quo * s_cur;
        s_prev = s_cur;
        s_cur  = nxt;
        nxt    = t_prev - quo * t_cur;
        t_prev = t_cur;
        t_cur  = nxt;
      end
      res.gcd_value    = r_prev;
      res.coeff_first  = s_prev;
      res.coeff_second = t_prev;
      return res;
    endfunction

    function void note_request(bit [W-1:0] a, bit [W-1:0] b);
      pairs_noted++;
      bezout_due.push_back(solve_bezout(a, b));
    endfunction

    function void compare_field(string field, bit [W-1:0] want, logic [W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, $signed(want), $signed(got));
        fails++;
      end
    endfunction

    function void check_result(logic [W-1:0] g, logic [W-1:0] cf, logic [W-1:0] cs);
      bezout_t want;
      results_seen++;
      if (bezout_due.size() == 0) begin
        $error("result beat with nothing outstanding: gcd_value %0d", $signed(g));
        fails++;
        return;
      end
      want = bezout_due.pop_front();
      compare_field("gcd_value", want.gcd_value, g);
      compare_field("coeff_first", want.coeff_first, cf);
      compare_field("coeff_second", want.coeff_second, cs);
    endfunction

    function int outstanding();
      return bezout_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  egcd_in_if  #(.DATA_WIDTH(W)) req ();
  egcd_out_if #(.DATA_WIDTH(W)) rsp ();

  extended_gcd_bezout_unit #(.DATA_WIDTH(W)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  bezout_ledger ledger = new();
  bit           gaps_on = 1'b1;
  int           hold_left = 0;
  bit [W-1:0]   fib_seq [0:46];

  always #5 clk = ~clk;

  // random value confined to a signed span of the given bit count
  function automatic word_t rand_span(int bits);
    word_t v;
    v = $urandom;
    return v >>> (W - bits);
  endfunction

  function automatic word_t special_pick();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return {1'b1, {(W-1){1'b0}}};
      4: return {1'b0, {(W-1){1'b1}}};
      5: return {1'b1, {(W-2){1'b0}}, 1'b1};
      6: return 2;
      default: return -2;
    endcase
  endfunction

  task automatic send_pair(input word_t a, input word_t b);
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.first_value  <= a;
    req.second_value <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    ledger.note_request(a, b);
  endtask

  task automatic wait_results_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() > 0) @(posedge clk);
  endtask

  // result side: check each beat, then pick ready for the next cycle
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        ledger.check_result(rsp.gcd_value, rsp.coeff_first, rsp.coeff_second);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < 34) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    word_t a, b, g;
    int    sel, k;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.first_value  <= '0;
    req.second_value <= '0;
    fib_seq[0] = 0;
    fib_seq[1] = 1;
    for (int i = 2; i <= 46; i++) fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero operands, extremes, sign mixes, minimum by minus one, deepest pair
    send_pair(0, 0);
    send_pair(5, 0);
    send_pair(-7, 0);
    send_pair(0, 5);
    send_pair(0, -5);
    send_pair({1'b1, {(W-1){1'b0}}}, -1);
    send_pair(-1, {1'b1, {(W-1){1'b0}}});
    send_pair({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}});
    send_pair({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}});
    send_pair({1'b1, {(W-1){1'b0}}}, 0);
    send_pair({1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}});
    send_pair({1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}});
    send_pair({1'b1, {(W-1){1'b0}}}, 2);
    send_pair({1'b0, {(W-1){1'b1}}}, -1);
    send_pair(12, 18);
    send_pair(-12, 18);
    send_pair(12, -18);
    send_pair(-12, -18);
    send_pair(1, 1);
    send_pair(-1, -1);
    send_pair(240, 46);
    send_pair(fib_seq[46], fib_seq[45]);
    send_pair(-fib_seq[46], fib_seq[45]);
    wait_results_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) hold_left = LONG_HOLD;
      if (n == 500) gaps_on = 1'b0;
      if (n == 700) gaps_on = 1'b1;
      if (n == 800) wait_results_drained();
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        a = $urandom;
        b = $urandom;
      end else if (sel < 65) begin
        a = rand_span($urandom_range(2, 16));
        b = rand_span($urandom_range(2, 16));
      end else if (sel < 85) begin
        g = rand_span(10);
        a = g * rand_span(11);
        b = g * rand_span(11);
      end else if (sel < 95) begin
        a = special_pick();
        b = $urandom_range(0, 1) ? special_pick() : word_t'($urandom);
        if ($urandom_range(0, 1)) begin
          g = a;
          a = b;
          b = g;
        end
      end else begin
        k = $urandom_range(30, 45);
        a = $urandom_range(0, 1) ? -fib_seq[k+1] : fib_seq[k+1];
        b = $urandom_range(0, 1) ? -fib_seq[k] : fib_seq[k];
      end
      send_pair(a, b);
    end
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d operand pairs (directed edges, wide, narrow, shared-factor, fibonacci)",
             ledger.pairs_noted);
    $display("compared %0d result beats, %0d field mismatches", ledger.results_seen,
             ledger.fails);
    if (ledger.fails == 0 && ledger.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
